/* rtl/core/tccb_pkg.sv */
// tccb_pkg: shared types and constants for the text console character buffer
// item field widths, request codes and sequencer states; no dependencies

package tccb_pkg;

  localparam int REQ_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 8;
  localparam int ROW_FLD_W  = 5;
  localparam int COL_FLD_W  = 7;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ADD_NL,
    S_ADD_WR,
    S_REM,
    S_SWEEP,
    S_RD,
    S_DONE
  } state_t;

endpackage

/* rtl/core/tccb_if.sv */
// tccb_in_if / tccb_out_if: valid/ready channels of the console buffer
// depends on tccb_pkg for field widths

interface tccb_in_if import tccb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [CHAR_W-1:0]    char_code;
  logic [COUNT_W-1:0]   remove_count;
  logic [ROW_FLD_W-1:0] read_row;
  logic [COL_FLD_W-1:0] read_column;

  modport source (output valid, req_type, char_code, remove_count, read_row, read_column,
                  input ready);
  modport sink   (input valid, req_type, char_code, remove_count, read_row, read_column,
                  output ready);
endinterface

interface tccb_out_if import tccb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    read_char;
  logic [ROW_FLD_W-1:0] cursor_row;
  logic [COL_FLD_W-1:0] cursor_column;
  logic                 scrolled;

  modport source (output valid, read_char, cursor_row, cursor_column, scrolled,
                  input ready);
  modport sink   (input valid, read_char, cursor_row, cursor_column, scrolled,
                  output ready);
endinterface

/* rtl/core/text_console_char_buffer.sv */
// text_console_char_buffer: ROWS x COLUMNS character grid with cursor and scroll
// depends on tccb_pkg and the channel interfaces in tccb_if.sv
//
// Usage: requests enter on in_ch (add character, remove characters, clear grid,
// read cell); every request gives exactly one item on out_ch carrying the read
// code (zero unless a read), the cursor after the request and a scroll flag.
// One request is worked at a time; in_ch.ready is high only while the
// sequencer is idle. Adds, removes and reads address one single-port cell memory
// through one address unit (physical row times COLUMNS plus column).
// Scrolling rotates a top-row pointer and then zeroes one row.
// Steps from acceptance to the result item:
//   add character   newline check, then cell write; a row sweep between if it scrolls
//   remove          one erase per cell (number erased clamped to the cursor column)
//   clear grid      zero all ROWS*COLUMNS cells (one cell zeroed per cycle)
//   read cell       one cell read
// The result sits in an output register; a new request is taken while it
// waits, and the sequencer holds its next result until out_ch.ready frees it.
// After reset a clearing pass zeroes all ROWS*COLUMNS cells, one a cycle,
// with in_ch.ready low; the cursor starts at row 0, column 0.

module text_console_char_buffer
  import tccb_pkg::*;
#(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  tccb_in_if.sink    in_ch,
  tccb_out_if.source out_ch
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = $clog2(CELLS);

  state_t               state_r, state_nxt;
  req_t                 req_r, req_nxt;
  logic [CHAR_W-1:0]    code_r, code_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [ROW_FLD_W-1:0] rrow_r, rrow_nxt;
  logic [COL_FLD_W-1:0] rcol_r, rcol_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        top_r, top_nxt;
  logic                 scrolled_r, scrolled_nxt;
  logic                 rd_hit_r, rd_hit_nxt;
  logic [AW-1:0]        sweep_addr_r, sweep_addr_nxt;
  logic [AW-1:0]        sweep_end_r, sweep_end_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic [ROW_FLD_W-1:0] out_row_r, out_row_nxt;
  logic [COL_FLD_W-1:0] out_col_r, out_col_nxt;
  logic                 out_scr_r, out_scr_nxt;

  // shared address unit
  logic [RW-1:0] au_row;
  logic [CW-1:0] au_col;
  logic [RW:0]   phys_sum;
  logic [RW-1:0] phys_row;
  logic [AW-1:0] au_addr;

  // cell memory
  logic [CHAR_W-1:0] mem [CELLS];
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [CHAR_W-1:0] rdata_r;

  logic need_nl;
  logic last_row;
  logic in_range;

  assign need_nl  = (col_r >= CW'(COLUMNS - 1)) || (code_r == NEWLINE_CODE);
  assign last_row = (row_r == RW'(ROWS - 1));
  assign in_range = (32'(rrow_r) < ROWS) && (32'(rcol_r) < COLUMNS);

  always_comb begin
    unique case (state_r)
      S_ADD_NL: begin
        au_row = '0;
        au_col = '0;
      end
      S_REM: begin
        au_row = row_r;
        au_col = col_r - CW'(1);
      end
      S_RD: begin
        au_row = RW'(rrow_r);
        au_col = CW'(rcol_r);
      end
      default: begin
        au_row = row_r;
        au_col = col_r;
      end
    endcase
    phys_sum = (RW+1)'(au_row) + (RW+1)'(top_r);
    if (32'(phys_sum) >= ROWS) begin
      phys_row = RW'(phys_sum - (RW+1)'(ROWS));
    end else begin
      phys_row = RW'(phys_sum);
    end
    au_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(au_col);
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    code_nxt       = code_r;
    count_nxt      = count_r;
    rrow_nxt       = rrow_r;
    rcol_nxt       = rcol_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    top_nxt        = top_r;
    scrolled_nxt   = scrolled_r;
    rd_hit_nxt     = rd_hit_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_end_nxt  = sweep_end_r;
    out_valid_nxt  = out_valid_r;
    out_char_nxt   = out_char_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_scr_nxt    = out_scr_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = au_addr;
    mem_wdata      = '0;
    in_ch.ready    = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr_r;
        sweep_addr_nxt = sweep_addr_r + AW'(1);
        if (sweep_addr_r == sweep_end_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          req_nxt      = req_t'(in_ch.req_type);
          code_nxt     = in_ch.char_code;
          count_nxt    = in_ch.remove_count;
          rrow_nxt     = in_ch.read_row;
          rcol_nxt     = in_ch.read_column;
          scrolled_nxt = 1'b0;
          rd_hit_nxt   = 1'b0;
          unique case (req_t'(in_ch.req_type))
            REQ_ADD:    state_nxt = S_ADD_NL;
            REQ_REMOVE: state_nxt = S_REM;
            REQ_CLEAR: begin
              top_nxt        = '0;
              row_nxt        = '0;
              col_nxt        = '0;
              sweep_addr_nxt = '0;
              sweep_end_nxt  = AW'(CELLS - 1);
              state_nxt      = S_SWEEP;
            end
            REQ_READ:   state_nxt = S_RD;
          endcase
        end
      end
      S_ADD_NL: begin
        state_nxt = S_ADD_WR;
        if (need_nl) begin
          col_nxt = '0;
          if (last_row) begin
            // old top row becomes the new bottom row and is zeroed
            scrolled_nxt   = 1'b1;
            top_nxt        = (top_r == RW'(ROWS - 1)) ? '0 : top_r + RW'(1);
            sweep_addr_nxt = au_addr;
            sweep_end_nxt  = au_addr + AW'(COLUMNS - 1);
            state_nxt      = S_SWEEP;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end
      end
      S_ADD_WR: begin
        if (code_r != NEWLINE_CODE) begin
          mem_we    = 1'b1;
          mem_wdata = code_r;
          col_nxt   = col_r + CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_REM: begin
        if (count_r == '0 || col_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          mem_we    = 1'b1;
          col_nxt   = col_r - CW'(1);
          count_nxt = count_r - COUNT_W'(1);
        end
      end
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr_r;
        sweep_addr_nxt = sweep_addr_r + AW'(1);
        if (sweep_addr_r == sweep_end_r) begin
          state_nxt = (req_r == REQ_CLEAR) ? S_DONE : S_ADD_WR;
        end
      end
      S_RD: begin
        mem_re     = in_range;
        rd_hit_nxt = in_range;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rd_hit_r ? rdata_r : '0;
          out_row_nxt   = ROW_FLD_W'(row_r);
          out_col_nxt   = COL_FLD_W'(col_r);
          out_scr_nxt   = scrolled_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      row_r        <= '0;
      col_r        <= '0;
      top_r        <= '0;
      sweep_addr_r <= '0;
      sweep_end_r  <= AW'(CELLS - 1);
      out_valid_r  <= 1'b0;
      req_r        <= REQ_ADD;
      scrolled_r   <= 1'b0;
      rd_hit_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      top_r        <= top_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_end_r  <= sweep_end_nxt;
      out_valid_r  <= out_valid_nxt;
      req_r        <= req_nxt;
      scrolled_r   <= scrolled_nxt;
      rd_hit_r     <= rd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r    <= code_nxt;
    count_r   <= count_nxt;
    rrow_r    <= rrow_nxt;
    rcol_r    <= rcol_nxt;
    out_char_r <= out_char_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
    out_scr_r <= out_scr_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[au_addr];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_char     = out_char_r;
  assign out_ch.cursor_row    = out_row_r;
  assign out_ch.cursor_column = out_col_r;
  assign out_ch.scrolled      = out_scr_r;

`ifndef SYNTH
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < ROWS) && (32'(col_r) < COLUMNS) && (32'(top_r) < ROWS))
    else $error("cursor or top-row pointer outside the grid");

  a_write_in_memory: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < CELLS))
    else $error("cell write beyond the memory");

  a_scroll_lands_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && scrolled_r) |-> (last_row && col_r <= CW'(1)))
    else $error("scroll left the cursor off the last row");

  a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && req_r == REQ_CLEAR) |-> (top_r == '0 && row_r == '0 && col_r == '0))
    else $error("grid clear did not home the cursor");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ch.ready) |=> (state_r == S_DONE))
    else $error("result overwritten while the previous item was stalled");
`endif

endmodule
